// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define NPPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the trigger
`define NPPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition holds at every edge
`define NPPS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== hw/rtl/npps_pkg.sv =====
// types and constants of the priority scheduler
`default_nettype none

package npps_pkg;

   localparam int MAX_PROCESSES = 64;
   localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
   localparam int ARR_W  = 16;
   localparam int BUR_W  = 16;
   localparam int PRI_W  = 8;
   localparam int ID_W   = 7;
   localparam int TIME_W = 24;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 120;

   typedef struct packed {
      logic [PRI_W-1:0] prio;
      logic [BUR_W-1:0] burst;
      logic [ARR_W-1:0] arrival;
   } job_entry_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      job_entry_type     job;
   } cand_type;

   typedef struct packed {
      logic              clear;
      logic              mark;
      logic [IDX_W-1:0]  mark_idx;
      logic              scan_start;
      logic              rd_valid;
      logic [IDX_W-1:0]  rd_idx;
   } sel_ctrl_type;

   typedef enum logic [1:0] {
      S_LOAD,
      S_SCAN,
      S_PICK,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/nonpreemptive_priority_scheduler_unit.sv =====
// top level of the non-preemptive priority scheduler
//
// req channel: one job per item, tdata = {priority, burst, arrival}, tlast marks
// the final job of a set. Jobs are numbered 1 upward in load order; up to
// MAX_PROCESSES are kept, later ones are dropped and set the overflow flag.
// Loading accepts one item per cycle. The item carrying tlast starts the schedule.
// rsp channel: one item per scheduled job in execution order, with completion,
// turnaround and waiting times; tuser carries overflow, tlast the final result.
// Each result needs a scan of the job table through its single read port,
// followed by a pick step and an emit step.
// req_tready is low while a schedule runs; the next set may load while the
// final result still waits in the output register.
// A stalled rsp side holds the output register and pauses the schedule.
// Reset (synchronous) clears the job count, done flags, clock and overflow;
// the job table itself needs no clearing since only loaded entries are read.
`default_nettype none

`include "assert_macros.svh"

module nonpreemptive_priority_scheduler_unit
   import npps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: arrival_time[15:0], burst_time[31:16], job_priority[39:32]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // rsp_tdata: job_id[6:0], job_arrival[22:7], job_burst[38:23], job_prio[46:39],
   // completion_time[70:47], turnaround_time[94:71], waiting_time[118:95], pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: overflow
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready
);

   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_PROCESSES);

   state_type state_ff, state_in;

   // set and schedule bookkeeping
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff;

   // picked job and its times
   cand_type          pick_ff, pick_in;
   logic [TIME_W-1:0] compl_ff, compl_in;
   logic [TIME_W-1:0] wait_ff, wait_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic              req_fire;
   logic              issue;
   logic              scan_done;
   logic              emit_fire;
   logic              emit_last;
   logic [TIME_W-1:0] start_time;
   logic [TIME_W-1:0] turn_time;
   job_entry_type     req_job;
   job_entry_type     rd_data;
   sel_ctrl_type      sel_ctrl;
   cand_type          cand_arr;
   cand_type          cand_early;

   assign req_job   = job_entry_type'(req_tdata);
   assign req_fire  = req_tvalid && req_tready;
   assign issue     = (state_ff == S_SCAN) && (issue_ff < count_ff);
   assign scan_done = (state_ff == S_SCAN) && (issue_ff == count_ff) && !rd_pend_ff;
   assign emit_fire = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign emit_last = (k_ff + CNT_ONE) == count_ff;

   npps_job_mem u_mem (
      .clock   (clock),
      .wr_en   (req_fire && (count_ff < CNT_CAP)),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_job),
      .rd_en   (issue),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   npps_select u_sel (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (sel_ctrl),
      .rd_data    (rd_data),
      .time_now   (time_ff),
      .cand_arr   (cand_arr),
      .cand_early (cand_early)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_fire && req_tlast) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_fire) begin
               state_in = emit_last ? S_LOAD : S_SCAN;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = (state_ff == S_LOAD);
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      time_in      = time_ff;
      k_in         = k_ff;
      issue_in     = issue_ff;
      rd_pend_in   = issue;
      pick_in      = pick_ff;
      compl_in     = compl_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      sel_ctrl     = '{clear: 1'b0, mark: 1'b0, mark_idx: pick_in.idx,
                       scan_start: 1'b0, rd_valid: rd_pend_ff, rd_idx: rd_idx_ff};
      // the clock jumps to the earliest pending arrival when nothing has arrived
      start_time = cand_arr.valid ? time_ff : TIME_W'(cand_early.job.arrival);
      turn_time  = compl_ff - TIME_W'(pick_ff.job.arrival);

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (count_ff < CNT_CAP) begin
                  count_in = count_ff + CNT_ONE;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_tlast) begin
                  sel_ctrl.scan_start = 1'b1;
                  issue_in            = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + CNT_ONE;
            end
         end
         S_PICK: begin
            pick_in           = cand_arr.valid ? cand_arr : cand_early;
            compl_in          = start_time + TIME_W'(pick_in.job.burst);
            wait_in           = start_time - TIME_W'(pick_in.job.arrival);
            time_in           = compl_in;
            sel_ctrl.mark     = 1'b1;
            sel_ctrl.mark_idx = pick_in.idx;
         end
         S_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, wait_ff, turn_time, compl_ff, pick_ff.job.prio,
                               pick_ff.job.burst, pick_ff.job.arrival,
                               ID_W'(pick_ff.idx) + ID_W'(1)};
               rsp_last_in  = emit_last;
               rsp_user_in  = overflow_ff;
               if (emit_last) begin
                  // set closed: back to the reset picture
                  count_in       = '0;
                  overflow_in    = 1'b0;
                  time_in        = '0;
                  k_in           = '0;
                  sel_ctrl.clear = 1'b1;
               end else begin
                  k_in                = k_ff + CNT_ONE;
                  issue_in            = '0;
                  sel_ctrl.scan_start = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         time_ff      <= '0;
         k_ff         <= '0;
         issue_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         time_ff      <= time_in;
         k_ff         <= k_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= issue_ff[IDX_W-1:0];
      pick_ff     <= pick_in;
      compl_ff    <= compl_in;
      wait_ff     <= wait_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   `NPPS_ASSERT_IMP(a_pick_has_cand, clock, reset, state_ff == S_PICK, cand_arr.valid || cand_early.valid, "no unfinished job found at pick")
   `NPPS_ASSERT_ALWAYS(a_count_cap, clock, reset, count_ff <= CNT_CAP, "job count beyond capacity")
   `NPPS_ASSERT_NXT(a_set_closes, clock, reset, emit_fire && emit_last, (count_ff == '0) && (state_ff == S_LOAD), "set not closed after final result")

endmodule

`default_nettype wire

// ===== hw/rtl/npps_job_mem.sv =====
// job table: one write port, one registered read port
`default_nettype none

module npps_job_mem
   import npps_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire job_entry_type  wr_data,
   input  wire logic           rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output job_entry_type       rd_data
);

   job_entry_type mem [MAX_PROCESSES];
   job_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/npps_select.sv =====
// done flags and running best-candidate search over the job table
`default_nettype none

module npps_select
   import npps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sel_ctrl_type      ctrl,
   input  wire job_entry_type     rd_data,
   input  wire logic [TIME_W-1:0] time_now,
   output cand_type               cand_arr,
   output cand_type               cand_early
);

   logic [MAX_PROCESSES-1:0] done_ff, done_in;
   cand_type                 arr_ff, arr_in;
   cand_type                 early_ff, early_in;
   logic                     live;
   logic                     arrived;
   logic                     arr_better;
   logic                     early_better;

   always_comb begin
      done_in = done_ff;
      if (ctrl.clear) begin
         done_in = '0;
      end else if (ctrl.mark) begin
         done_in[ctrl.mark_idx] = 1'b1;
      end
   end

   always_comb begin
      live    = ctrl.rd_valid && !done_ff[ctrl.rd_idx];
      arrived = TIME_W'(rd_data.arrival) <= time_now;
      // highest priority, then earliest arrival; equal keeps the lower id
      arr_better = !arr_ff.valid || (rd_data.prio > arr_ff.job.prio) ||
                   ((rd_data.prio == arr_ff.job.prio) &&
                    (rd_data.arrival < arr_ff.job.arrival));
      // earliest arrival, then highest priority; used when the clock jumps
      early_better = !early_ff.valid || (rd_data.arrival < early_ff.job.arrival) ||
                     ((rd_data.arrival == early_ff.job.arrival) &&
                      (rd_data.prio > early_ff.job.prio));
      arr_in   = arr_ff;
      early_in = early_ff;
      if (ctrl.scan_start) begin
         arr_in.valid   = 1'b0;
         early_in.valid = 1'b0;
      end else if (live) begin
         if (arrived && arr_better) begin
            arr_in = '{valid: 1'b1, idx: ctrl.rd_idx, job: rd_data};
         end
         if (early_better) begin
            early_in = '{valid: 1'b1, idx: ctrl.rd_idx, job: rd_data};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         arr_ff   <= '0;
         early_ff <= '0;
      end else begin
         done_ff  <= done_in;
         arr_ff   <= arr_in;
         early_ff <= early_in;
      end
   end

   assign cand_arr   = arr_ff;
   assign cand_early = early_ff;

endmodule

`default_nettype wire
